// ----- sv/primitive_assembler_unit_defines.svh -----
// Assertion macros shared by the checker.
`ifndef PRIMITIVE_ASSEMBLER_UNIT_DEFINES_SVH
`define PRIMITIVE_ASSEMBLER_UNIT_DEFINES_SVH

// Plain implication, checked while out of reset.
`define PAU_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication.
`define PAU_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ----- sv/pau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pau_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int OUT_BITS      = 32;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [1:0] CMD_BEGIN  = 2'd0;
	localparam logic [1:0] CMD_VERTEX = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;

	localparam logic [3:0] MODE_NONE   = 4'd0;
	localparam logic [3:0] MODE_POINTS = 4'd1;
	localparam logic [3:0] MODE_LINES  = 4'd2;
	localparam logic [3:0] MODE_LSTRIP = 4'd3;
	localparam logic [3:0] MODE_LOOP   = 4'd4;
	localparam logic [3:0] MODE_TRIS   = 4'd5;
	localparam logic [3:0] MODE_FAN    = 4'd6;
	localparam logic [3:0] MODE_TSTRIP = 4'd7;
	localparam logic [3:0] MODE_QUADS  = 4'd8;

	localparam logic [1:0] SHAPE_POINT = 2'd0;
	localparam logic [1:0] SHAPE_SEG   = 2'd1;
	localparam logic [1:0] SHAPE_TRI   = 2'd2;

	// Vertex source for one emitted vertex
	localparam logic [2:0] SRC_H0  = 3'd0;
	localparam logic [2:0] SRC_H1  = 3'd1;
	localparam logic [2:0] SRC_H2  = 3'd2;
	localparam logic [2:0] SRC_NEW = 3'd3;
	localparam logic [2:0] SRC_LF  = 3'd4;

	localparam int MAX_EMIT = 6;

	typedef struct packed {
		logic [2:0] src;
		logic [1:0] shape;
		logic [1:0] corner;
		logic       zero_uv;
		logic       col_lf;  // colour from loop-first vertex
		logic       last;
	} emit_t;

	// Emit plan handed from front to back: the emit count plus one entry per emit
	typedef struct packed {
		logic [2:0]               n_emit;
		emit_t [MAX_EMIT-1:0]     plan;
	} plan_t;
endpackage
`default_nettype wire

// ----- sv/pau_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pau_front import pau_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid,
	output logic                      stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [2:0]           prim_kind,
	input  wire logic                 quads_mode,
	// to queue
	output logic                      job_valid,
	input  wire logic                 job_full,
	output plan_t                     job_plan,
	output logic                      job_wr,       // store write enable
	output logic [1:0]                job_wr_slot,
	output logic                      job_wr_lf,
	output logic                      job_lf_cmp   // end of loop: compare needed
);
	logic [3:0] mode_q;
	logic [1:0] cnt_q;
	logic       up_q;
	logic       acc;
	plan_t      p;
	logic       wr, wlf, cmpe;
	logic [1:0] wslot;
	logic [3:0] mode_d;
	logic [1:0] cnt_d;
	logic       up_d;

	assign stall = job_full;
	assign acc   = valid && !job_full;

	function automatic emit_t em(logic [2:0] s, logic [1:0] sh, logic [1:0] c,
		logic z, logic lf, logic l);
		emit_t e;
		e.src = s; e.shape = sh; e.corner = c; e.zero_uv = z; e.col_lf = lf; e.last = l;
		return e;
	endfunction

	always_comb begin
		p = '0;
		wr = 1'b0; wlf = 1'b0; wslot = 2'd0; cmpe = 1'b0;
		mode_d = mode_q; cnt_d = cnt_q; up_d = up_q;
		case (cmd)
			CMD_BEGIN: begin
				mode_d = quads_mode ? MODE_QUADS : {1'b0, prim_kind};
				cnt_d = 2'd0; up_d = 1'b1;
			end
			CMD_END: begin
				if (mode_q == MODE_LOOP && cnt_q != 2'd0) begin
					cmpe = 1'b1;
					p.n_emit = 3'd2;
					p.plan[0] = em(SRC_H0, SHAPE_SEG, 2'd0, 1'b0, 1'b1, 1'b0);
					p.plan[1] = em(SRC_LF, SHAPE_SEG, 2'd1, 1'b0, 1'b1, 1'b1);
				end
				mode_d = MODE_NONE; cnt_d = 2'd0; up_d = 1'b1;
			end
			CMD_VERTEX: begin
				case (mode_q)
					MODE_POINTS: begin
						p.n_emit = 3'd1;
						p.plan[0] = em(SRC_NEW, SHAPE_POINT, 2'd0, 1'b0, 1'b0, 1'b1);
					end
					MODE_LINES, MODE_LSTRIP, MODE_LOOP: begin
						if (cnt_q == 2'd1) begin
							p.n_emit = 3'd2;
							p.plan[0] = em(SRC_H0, SHAPE_SEG, 2'd0, 1'b0, 1'b0, 1'b0);
							p.plan[1] = em(SRC_NEW, SHAPE_SEG, 2'd1, 1'b0, 1'b0, 1'b1);
							if (mode_q == MODE_LINES) cnt_d = 2'd0;
							else wr = 1'b1;
						end else begin
							wr = 1'b1; wlf = (mode_q == MODE_LOOP); cnt_d = 2'd1;
						end
					end
					MODE_TRIS, MODE_FAN, MODE_TSTRIP: begin
						if (cnt_q >= 2'd2) begin
							p.n_emit = 3'd3;
							p.plan[0] = em(SRC_H0, SHAPE_TRI, 2'd0, 1'b0, 1'b0, 1'b0);
							p.plan[1] = em(SRC_H1, SHAPE_TRI, 2'd1, 1'b0, 1'b0, 1'b0);
							p.plan[2] = em(SRC_NEW, SHAPE_TRI, 2'd2, 1'b0, 1'b0, 1'b1);
							if (mode_q == MODE_TRIS) cnt_d = 2'd0;
							else if (mode_q == MODE_FAN) begin
								wr = 1'b1; wslot = 2'd1;
							end else begin
								wr = 1'b1; wslot = up_q ? 2'd0 : 2'd1; up_d = !up_q;
							end
						end else begin
							wr = 1'b1; wslot = cnt_q; cnt_d = cnt_q + 2'd1;
						end
					end
					MODE_QUADS: begin
						if (cnt_q == 2'd3) begin
							p.n_emit = 3'd6;
							p.plan[0] = em(SRC_H0, SHAPE_TRI, 2'd0, 1'b0, 1'b0, 1'b0);
							p.plan[1] = em(SRC_H1, SHAPE_TRI, 2'd1, 1'b0, 1'b0, 1'b0);
							p.plan[2] = em(SRC_H2, SHAPE_TRI, 2'd2, 1'b0, 1'b0, 1'b0);
							p.plan[3] = em(SRC_H0, SHAPE_TRI, 2'd0, 1'b1, 1'b0, 1'b0);
							p.plan[4] = em(SRC_H2, SHAPE_TRI, 2'd1, 1'b1, 1'b0, 1'b0);
							p.plan[5] = em(SRC_NEW, SHAPE_TRI, 2'd2, 1'b0, 1'b0, 1'b1);
							cnt_d = 2'd0;
						end else begin
							wr = 1'b1; wslot = cnt_q; cnt_d = cnt_q + 2'd1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Only items with work go to the back
	assign job_valid   = acc && (p.n_emit != 3'd0 || wr || cmpe);
	assign job_plan    = p;
	assign job_wr      = wr;
	assign job_wr_slot = wslot;
	assign job_wr_lf   = wlf;
	assign job_lf_cmp  = cmpe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE; cnt_q <= 2'd0; up_q <= 1'b1;
		end else if (acc) begin
			mode_q <= mode_d; cnt_q <= cnt_d; up_q <= up_d;
		end
	end
endmodule
`default_nettype wire

// ----- sv/pau_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pau_back import pau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 job_valid,
	output logic                      job_take,
	input  wire plan_t                job_plan,
	input  wire logic                 job_wr,
	input  wire logic [1:0]           job_wr_slot,
	input  wire logic                 job_wr_lf,
	input  wire logic                 job_lf_cmp,
	input  wire logic [WORD_BITS-1:0] job_v [6],
	output logic                      valid,
	input  wire logic                 stall,
	output logic [1:0]                shape_kind,
	output logic [1:0]                corner,
	output logic [OUT_BITS-1:0]       out_w [6],
	output logic                      last
);
	logic [WORD_BITS-1:0] held_q [3][6];
	logic [WORD_BITS-1:0] lf_q [6];
	logic [2:0]           idx_q;
	logic [2:0]           n_eff;
	logic                 same;
	logic                 load;
	emit_t                e;
	logic [WORD_BITS-1:0] sv [6];
	logic [WORD_BITS-1:0] cw;

	assign load = !valid || !stall;
	assign same = (held_q[0][0] == lf_q[0]) && (held_q[0][1] == lf_q[1]) &&
		(held_q[0][2] == lf_q[2]);
	assign n_eff = (job_lf_cmp && same) ? 3'd0 : job_plan.n_emit;
	assign e = job_plan.plan[idx_q];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			case (e.src)
				SRC_H0:  sv[i] = held_q[0][i];
				SRC_H1:  sv[i] = held_q[1][i];
				SRC_H2:  sv[i] = held_q[2][i];
				SRC_LF:  sv[i] = lf_q[i];
				default: sv[i] = job_v[i];
			endcase
		end
		// segments carry the colour of the vertex that completes them
		cw = e.col_lf ? lf_q[5] : ((e.shape == SHAPE_SEG) ? job_v[5] : sv[5]);
	end

	// Item retires on its last emit, or at once when it emits nothing
	assign job_take = job_valid && ((n_eff == 3'd0) ||
		(load && idx_q == n_eff - 3'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0; idx_q <= 3'd0;
		end else begin
			if (load) valid <= job_valid && n_eff != 3'd0;
			if (job_take) idx_q <= 3'd0;
			else if (job_valid && load) idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid && n_eff != 3'd0) begin
			shape_kind <= e.shape;
			corner     <= e.corner;
			last       <= e.last;
			for (int i = 0; i < 5; i++)
				out_w[i] <= (e.zero_uv && (i == 3 || i == 4)) ? '0 :
					OUT_BITS'(sv[i]);
			out_w[5] <= OUT_BITS'(cw);
		end
		if (job_take && job_wr) held_q[job_wr_slot] <= job_v;
		if (job_take && job_wr_lf) lf_q <= job_v;
	end
endmodule
`default_nettype wire

// ----- sv/pau_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pau_queue import pau_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         rd,
	output logic              nonempty,
	output logic [W-1:0]      rdata
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- sv/primitive_assembler_unit.sv -----
// An accepted vertex passes through the queue and then the output register to its first result.
// The back end gives one result per cycle while out_stall is low; an item stays at the head
// of the queue until its last result is loaded, and an item that emits nothing retires at once.
// The front takes one request per cycle while the 4-entry queue has room.
// Reset: arst_n clears mode, counters, strip toggle, queue pointers and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module primitive_assembler_unit import pau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [2:0]           prim_kind,
	input  wire logic                 quads_mode,
	input  wire logic [WORD_BITS-1:0] pos_x,
	input  wire logic [WORD_BITS-1:0] pos_y,
	input  wire logic [WORD_BITS-1:0] pos_z,
	input  wire logic [WORD_BITS-1:0] tex_u,
	input  wire logic [WORD_BITS-1:0] tex_v,
	input  wire logic [WORD_BITS-1:0] rgba,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                shape_kind,
	output logic [1:0]                corner,
	output logic [OUT_BITS-1:0]       out_x,
	output logic [OUT_BITS-1:0]       out_y,
	output logic [OUT_BITS-1:0]       out_z,
	output logic [OUT_BITS-1:0]       out_u,
	output logic [OUT_BITS-1:0]       out_v,
	output logic [OUT_BITS-1:0]       out_rgba,
	output logic                      last
);
	// Queue entry: plan, store controls and the vertex words
	localparam int QW = $bits(plan_t) + 5 + 6 * WORD_BITS;

	logic [WORD_BITS-1:0] vin [6];
	logic [WORD_BITS-1:0] qv [6];
	logic [OUT_BITS-1:0]  ow [6];
	plan_t      f_plan, q_plan;
	logic       f_valid, q_full, f_wr, f_lf, f_cmp;
	logic [1:0] f_slot, q_slot;
	logic       q_ne, q_rd, q_wr, q_lf, q_cmp;
	logic [QW-1:0] q_in, q_out;

	assign vin[0] = pos_x; assign vin[1] = pos_y; assign vin[2] = pos_z;
	assign vin[3] = tex_u; assign vin[4] = tex_v; assign vin[5] = rgba;

	// Front: tracks mode and counters, builds the emit plan per request
	pau_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .cmd, .prim_kind,
		.quads_mode, .job_valid(f_valid), .job_full(q_full),
		.job_plan(f_plan), .job_wr(f_wr), .job_wr_slot(f_slot), .job_wr_lf(f_lf),
		.job_lf_cmp(f_cmp)
	);

	assign q_in = {f_plan, f_wr, f_slot, f_lf, f_cmp,
		vin[0], vin[1], vin[2], vin[3], vin[4], vin[5]};
	assign {q_plan, q_wr, q_slot, q_lf, q_cmp,
		qv[0], qv[1], qv[2], qv[3], qv[4], qv[5]} = q_out;

	pau_queue #(.W(QW), .DEPTH(FIFO_DEPTH)) u_queue (
		.clk, .arst_n, .wr(f_valid), .wdata(q_in), .full(q_full),
		.rd(q_rd), .nonempty(q_ne), .rdata(q_out)
	);

	// Back: holds vertex slots, plays out the plan one result per cycle while out_stall is low
	pau_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk, .arst_n, .job_valid(q_ne), .job_take(q_rd), .job_plan(q_plan),
		.job_wr(q_wr), .job_wr_slot(q_slot), .job_wr_lf(q_lf), .job_lf_cmp(q_cmp),
		.job_v(qv), .valid(out_valid), .stall(out_stall), .shape_kind, .corner,
		.out_w(ow), .last
	);

	assign out_x = ow[0]; assign out_y = ow[1]; assign out_z = ow[2];
	assign out_u = ow[3]; assign out_v = ow[4]; assign out_rgba = ow[5];
endmodule
`default_nettype wire

// ----- sv/pau_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "primitive_assembler_unit_defines.svh"
module pau_checker import pau_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] shape_kind,
	input wire logic [1:0] corner,
	input wire logic       last
);
	`PAU_ASSERT_IMP(a_shape, clk, arst_n, out_valid, shape_kind == SHAPE_POINT || shape_kind == SHAPE_SEG || shape_kind == SHAPE_TRI)
	`PAU_ASSERT_IMP(a_pt, clk, arst_n, out_valid && shape_kind == SHAPE_POINT, corner == 2'd0 && last)
	`PAU_ASSERT_IMP(a_seg, clk, arst_n, out_valid && shape_kind == SHAPE_SEG, corner != 2'd2 && corner != 2'd3)
	`PAU_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(corner))
endmodule
bind primitive_assembler_unit pau_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .shape_kind, .corner, .last
);
`default_nettype wire

// ----- tb/primitive_assembler_unit_tb.sv -----
`timescale 1ns / 1ps
import pau_pkg::*;

// One emitted vertex as the block should present it
typedef struct {
	logic [1:0]  shape;
	logic [1:0]  crn;
	logic [31:0] x, y, z, u, v, c;
	logic        lst;
} vert_res_t;

typedef struct {
	logic [31:0] x, y, z, u, v, c;
} vert_t;

// Assembly predictor plus the queue of vertices still owed by the block
class assembly_board;
	logic [3:0] mode;
	int         held;
	bit         strip_up;
	vert_t      slot[3];
	vert_t      first;
	vert_res_t  owed[$];
	int         errors;

	function new();
		mode = MODE_NONE;
		held = 0;
		strip_up = 1;
		errors = 0;
	endfunction

	function void push_vert(logic [1:0] sh, logic [1:0] cn, vert_t p, bit zuv,
			logic [31:0] col);
		vert_res_t r;
		r.shape = sh;
		r.crn = cn;
		r.x = p.x;
		r.y = p.y;
		r.z = p.z;
		r.u = zuv ? 32'd0 : p.u;
		r.v = zuv ? 32'd0 : p.v;
		r.c = col;
		r.lst = 0;
		owed.insert(owed.size(), r);
	endfunction

	function void push_tri(vert_t a, vert_t b, vert_t c, bit zab);
		push_vert(SHAPE_TRI, 2'd0, a, zab, a.c);
		push_vert(SHAPE_TRI, 2'd1, b, zab, b.c);
		push_vert(SHAPE_TRI, 2'd2, c, 0, c.c);
	endfunction

	// note one accepted request and queue the vertices it causes
	function void note_request(logic [1:0] cmd, logic [2:0] kind, logic qm, vert_t nv);
		int n_prior;
		n_prior = owed.size();
		if (cmd == CMD_BEGIN) begin
			mode = qm ? MODE_QUADS : {1'b0, kind};
			held = 0;
			strip_up = 1;
		end else if (cmd == CMD_END) begin
			if (mode == MODE_LOOP && held != 0 && (slot[0].x != first.x ||
					slot[0].y != first.y || slot[0].z != first.z)) begin
				push_vert(SHAPE_SEG, 2'd0, slot[0], 0, first.c);
				push_vert(SHAPE_SEG, 2'd1, first, 0, first.c);
			end
			mode = MODE_NONE;
			held = 0;
			strip_up = 1;
		end else if (cmd == CMD_VERTEX) begin
			case (mode)
				MODE_POINTS: push_vert(SHAPE_POINT, 2'd0, nv, 0, nv.c);
				MODE_LINES, MODE_LSTRIP, MODE_LOOP: begin
					if (held == 1) begin
						push_vert(SHAPE_SEG, 2'd0, slot[0], 0, nv.c);
						push_vert(SHAPE_SEG, 2'd1, nv, 0, nv.c);
						if (mode == MODE_LINES) held = 0;
						else slot[0] = nv;
					end else begin
						slot[0] = nv;
						if (mode == MODE_LOOP) first = nv;
						held = 1;
					end
				end
				MODE_TRIS, MODE_FAN, MODE_TSTRIP: begin
					if (held >= 2) begin
						push_tri(slot[0], slot[1], nv, 0);
						if (mode == MODE_TRIS) held = 0;
						else if (mode == MODE_FAN) slot[1] = nv;
						else begin
							slot[strip_up ? 0 : 1] = nv;
							strip_up = !strip_up;
						end
					end else begin
						slot[held] = nv;
						held++;
					end
				end
				MODE_QUADS: begin
					if (held == 3) begin
						push_tri(slot[0], slot[1], slot[2], 0);
						push_tri(slot[0], slot[2], nv, 1);
						held = 0;
					end else begin
						slot[held] = nv;
						held++;
					end
				end
				default: ;
			endcase
		end
		if (owed.size() > n_prior) owed[owed.size()-1].lst = 1;
	endfunction

	function void check_vertex(vert_res_t got);
		vert_res_t e;
		if (owed.size() == 0) begin
			$error("unexpected result vertex");
			errors++;
			return;
		end
		e = owed.pop_front();
		if (got.shape !== e.shape) begin
			$error("shape_kind exp %0d got %0d", e.shape, got.shape); errors++; end
		if (got.crn !== e.crn) begin
			$error("corner exp %0d got %0d", e.crn, got.crn); errors++; end
		if (got.x !== e.x) begin $error("out_x exp %h got %h", e.x, got.x); errors++; end
		if (got.y !== e.y) begin $error("out_y exp %h got %h", e.y, got.y); errors++; end
		if (got.z !== e.z) begin $error("out_z exp %h got %h", e.z, got.z); errors++; end
		if (got.u !== e.u) begin $error("out_u exp %h got %h", e.u, got.u); errors++; end
		if (got.v !== e.v) begin $error("out_v exp %h got %h", e.v, got.v); errors++; end
		if (got.c !== e.c) begin
			$error("out_rgba exp %h got %h", e.c, got.c); errors++; end
		if (got.lst !== e.lst) begin
			$error("last exp %0d got %0d", e.lst, got.lst); errors++; end
	endfunction
endclass

module primitive_assembler_unit_tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_END;
	logic [2:0]  prim_kind = 0;
	logic        quads_mode = 0;
	logic [31:0] pos_x = 0, pos_y = 0, pos_z = 0, tex_u = 0, tex_v = 0, rgba = 0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [1:0]  shape_kind, corner;
	logic [31:0] out_x, out_y, out_z, out_u, out_v, out_rgba;
	logic        last;

	assembly_board board = new();
	bit          no_stall = 0;
	// a few recurring positions make loop closing vertices sometimes match the first
	logic [31:0] pos_pool[4] = '{32'h0, 32'hFFFFFFFF, 32'h3F800000, 32'h80000000};

	always #10 clk = ~clk;

	primitive_assembler_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .prim_kind(prim_kind), .quads_mode(quads_mode),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v), .rgba(rgba),
		.out_valid(out_valid), .out_stall(out_stall),
		.shape_kind(shape_kind), .corner(corner),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_u(out_u), .out_v(out_v), .out_rgba(out_rgba), .last(last)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one request and hold it until the block takes it
	task automatic send(logic [1:0] c, logic [2:0] k, logic q, vert_t p);
		repeat (gap_len()) @(negedge clk);
		cmd = c;
		prim_kind = k;
		quads_mode = q;
		pos_x = p.x; pos_y = p.y; pos_z = p.z;
		tex_u = p.u; tex_v = p.v; rgba = p.c;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(c, k, q, p);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic vert_t rand_vert(bit pooled);
		vert_t p;
		p.x = pooled ? pos_pool[$urandom_range(0, 3)] : $urandom;
		p.y = pooled ? pos_pool[$urandom_range(0, 3)] : $urandom;
		p.z = pooled ? pos_pool[$urandom_range(0, 3)] : $urandom;
		p.u = $urandom;
		p.v = $urandom;
		p.c = $urandom;
		return p;
	endfunction

	task automatic open_mode(logic [3:0] m);
		vert_t z;
		z = '{default: 0};
		if (m == MODE_QUADS) send(CMD_BEGIN, 3'($urandom), 1'b1, z);
		else send(CMD_BEGIN, m[2:0], 1'b0, z);
	endtask

	task automatic send_vertex(bit pooled);
		send(CMD_VERTEX, 3'($urandom), 1'($urandom), rand_vert(pooled));
	endtask

	task automatic close_mode();
		send(CMD_END, 3'($urandom), 1'($urandom), rand_vert(0));
	endtask

	// receiver: random stalls, sampled at the rising edge
	always @(negedge clk) begin
		if (!arst_n || no_stall) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 99) < 10) ? 1'b1 :
			(gap_len() > 0 && $urandom_range(0, 2) == 0);
	end

	always @(posedge clk) begin
		vert_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.shape = shape_kind;
			got.crn = corner;
			got.x = out_x; got.y = out_y; got.z = out_z;
			got.u = out_u; got.v = out_v; got.c = out_rgba;
			got.lst = last;
			board.check_vertex(got);
		end
	end

	initial begin
		vert_t ones, zeros;
		logic [3:0] m;
		int nv;
		ones = '{default: 32'hFFFFFFFF};
		zeros = '{default: 32'h0};
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: points, lines, loop and quads, field extremes, loop close and no-close, oddities
		send(CMD_VERTEX, 3'd0, 1'b0, ones);           // vertex with no mode: ignored
		open_mode(MODE_POINTS);
		send(CMD_VERTEX, 3'd7, 1'b1, ones);
		send(CMD_VERTEX, 3'd0, 1'b0, zeros);
		open_mode(MODE_LINES);                         // begin mid-primitive
		send_vertex(0); send_vertex(0); send_vertex(0);
		close_mode();                                  // unfinished line dropped
		open_mode(MODE_LOOP);
		send_vertex(0); send_vertex(0); send_vertex(0);
		close_mode();                                  // closing segment
		open_mode(MODE_LOOP);
		send(CMD_VERTEX, 3'd0, 1'b0, ones);
		send(CMD_VERTEX, 3'd0, 1'b0, zeros);
		send(CMD_VERTEX, 3'd0, 1'b0, ones);
		close_mode();                                  // last equals first: nothing
		send(2'd3, 3'd7, 1'b1, ones);                  // unused command
		open_mode(MODE_QUADS);
		repeat (4) send_vertex(0);

		// pause until the block has drained
		while (board.owed.size() != 0) @(negedge clk);

		// random: mostly well-formed primitives with random content, some noise
		nv = 0;
		while (nv < 150) begin
			m = 4'($urandom_range(0, 8));
			if ($urandom_range(0, 9) == 0) begin
				send(2'($urandom), 3'($urandom), 1'($urandom), rand_vert(1));
				nv++;
			end else begin
				open_mode(m);
				nv++;
				repeat ($urandom_range(1, 9)) begin
					send_vertex(m == MODE_LOOP && $urandom_range(0, 1));
					nv++;
				end
				if ($urandom_range(0, 3) != 0) begin
					close_mode();
					nv++;
				end
			end
			// stretch with the receiver always ready
			no_stall = ($urandom_range(0, 4) == 0);
		end
		close_mode();

		while (board.owed.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("primitive_assembler_unit verification clean");
		else
			$display("primitive_assembler_unit verification failed");
		$finish;
	end

	// generous watchdog
	initial begin
		#5ms;
		$display("primitive_assembler_unit verification failed");
		$finish;
	end
endmodule
